// ===== sv/s2d9m_pkg.sv =====
// ----------------------------------------------------------------------------
// s2d9m_pkg
// Shared types, constants and helpers for the 3x3 box mean block.
// ----------------------------------------------------------------------------
package s2d9m_pkg;

  // widths of the fixed fields
  localparam int SAMPLE_W = 32;
  localparam int IDX_W    = 10;
  localparam int ROWS_W   = 11;
  localparam int STEP_W   = 4;
  localparam int CFG_W    = 11;

  // frame dimension arithmetic, wide enough for 4096 plus a step
  localparam int DIM_W = 13;

  // column sum of three samples, window sum of nine
  localparam int COLSUM_W = SAMPLE_W + 2;
  localparam int SUM_W    = SAMPLE_W + 4;
  localparam int MAG_W    = SUM_W - 1;

  // divide by 9: q = ((mag + 4) * RECIP9) >> RECIP_SHIFT, exact for mag < 2^35
  localparam int            RECIP_SHIFT = 38;
  localparam logic [34:0]   RECIP9      = 35'd30541989661;
  localparam int            LO_W        = 17;
  localparam int            HI_W        = MAG_W - LO_W;
  localparam logic [HI_W-1:0] RECIP9_HI = RECIP9[34:17];
  localparam logic [LO_W-1:0] RECIP9_LO = RECIP9[16:0];
  localparam int            PROD_W      = 2 * MAG_W;
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(4);

  // step divisibility by modular inverse of the odd part
  localparam int          DIV_W = 16;
  localparam logic [15:0] INV3  = 16'hAAAB;
  localparam logic [15:0] LIM3  = 16'd21845;
  localparam logic [15:0] INV5  = 16'hCCCD;
  localparam logic [15:0] LIM5  = 16'd13107;
  localparam logic [15:0] INV7  = 16'h6DB7;
  localparam logic [15:0] LIM7  = 16'd9362;

  localparam logic [STEP_W-1:0] STEP_MIN = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MAX = 4'd8;
  localparam logic [DIM_W-1:0]  DIM_MIN  = 13'd3;

  // depths of the queue between the parts and of the output queue
  localparam int MQ_DEPTH = 4;
  localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1,
    REG_STEP_SIZE = 2'd2
  } cfg_reg_t;

  localparam logic [ROWS_W-1:0] GRID_ROWS_RST = 11'd1024;
  localparam logic [ROWS_W-1:0] GRID_COLS_RST = 11'd1024;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST = 4'd1;

  typedef struct packed {
    logic [ROWS_W-1:0] grid_rows;
    logic [ROWS_W-1:0] grid_cols;
    logic [STEP_W-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } res_tag_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] total;
    res_tag_t                tag;
  } mid_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    res_tag_t                   tag;
  } out_item_t;

  // true when step divides x, step already clamped to 1..8
  function automatic logic step_divides(input logic [DIV_W-1:0] x,
                                        input logic [STEP_W-1:0] step);
    logic [31:0] p3;
    logic [31:0] p5;
    logic [31:0] p7;
    logic [31:0] p6;
    logic        hit;
    p3 = 32'(x) * 32'(INV3);
    p5 = 32'(x) * 32'(INV5);
    p7 = 32'(x) * 32'(INV7);
    p6 = 32'({1'b0, x[DIV_W-1:1]}) * 32'(INV3);
    case (step)
      4'd1:    hit = 1'b1;
      4'd2:    hit = !x[0];
      4'd3:    hit = (p3[15:0] <= LIM3);
      4'd4:    hit = (x[1:0] == 2'b00);
      4'd5:    hit = (p5[15:0] <= LIM5);
      4'd6:    hit = !x[0] && (p6[15:0] <= LIM3);
      4'd7:    hit = (p7[15:0] <= LIM7);
      4'd8:    hit = (x[2:0] == 3'b000);
      default: hit = 1'b1;
    endcase
    return hit;
  endfunction

endpackage

// ===== sv/s2d9m_queue.sv =====
// ----------------------------------------------------------------------------
// s2d9m_queue
// Small register queue with occupancy count, used between and after the parts.
// ----------------------------------------------------------------------------
module s2d9m_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_pop;

  assign empty    = (count == '0);
  assign do_pop   = pop && !empty;
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // upstream credit logic must never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CW'(DEPTH)))
    else $error("queue pushed while full");

endmodule

// ===== sv/s2d9m_front.sv =====
// ----------------------------------------------------------------------------
// s2d9m_front
// Raster counters, line memory, column-sum window and result classification.
// ----------------------------------------------------------------------------
module s2d9m_front #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  s2d9m_pkg::cfg_t                      cfg,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [s2d9m_pkg::SAMPLE_W-1:0] sample,
  input  logic [s2d9m_pkg::MQ_CW-1:0]          mq_count,
  output logic                                 mq_push,
  output s2d9m_pkg::mid_item_t                 mq_item
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLS);
  localparam int DW   = s2d9m_pkg::DIM_W;
  localparam int SW   = s2d9m_pkg::SAMPLE_W;
  localparam int CSW  = s2d9m_pkg::COLSUM_W;
  localparam int TW   = s2d9m_pkg::SUM_W;
  localparam int IW   = s2d9m_pkg::IDX_W;
  localparam int CU_W = s2d9m_pkg::MQ_CW + 1;

  // clamped frame settings
  logic [DW-1:0]                    rows_c;
  logic [DW-1:0]                    cols_c;
  logic [s2d9m_pkg::STEP_W-1:0]     step_c;

  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count_next;
  logic [CW-1:0] col_count_next;
  logic [DW-1:0] row_inc;
  logic [DW-1:0] r_now;
  logic [DW-1:0] c_now;
  logic [DW-1:0] r_plus;
  logic [DW-1:0] c_plus;
  logic          col_wrap;
  logic          accept;
  logic [CU_W-1:0] credit_used;

  logic [2*SW-1:0]       line_mem [MAX_COLS];
  logic [2*SW-1:0]       line_rd;

  logic                  s1_valid;
  logic [RW-1:0]         s1_row;
  logic [CW-1:0]         s1_col;
  logic signed [SW-1:0]  s1_cur;
  logic signed [SW-1:0]  s1_up;
  logic signed [SW-1:0]  s1_mid;
  logic signed [CSW-1:0] col_sum;
  logic [DW-1:0]         row_e;
  logic [DW-1:0]         col_e;
  logic [DW-1:0]         cr;
  logic [DW-1:0]         cc;
  logic                  s1_res;
  logic                  s1_last;

  logic signed [CSW-1:0] win [3];
  logic                  s2_valid;
  logic                  s2_res;
  logic [IW-1:0]         s2_row;
  logic [IW-1:0]         s2_col;
  logic                  s2_last;

  always_comb begin
    if (DW'(cfg.grid_rows) < s2d9m_pkg::DIM_MIN) begin
      rows_c = s2d9m_pkg::DIM_MIN;
    end else if (DW'(cfg.grid_rows) > DW'(MAX_ROWS)) begin
      rows_c = DW'(MAX_ROWS);
    end else begin
      rows_c = DW'(cfg.grid_rows);
    end
    if (DW'(cfg.grid_cols) < s2d9m_pkg::DIM_MIN) begin
      cols_c = s2d9m_pkg::DIM_MIN;
    end else if (DW'(cfg.grid_cols) > DW'(MAX_COLS)) begin
      cols_c = DW'(MAX_COLS);
    end else begin
      cols_c = DW'(cfg.grid_cols);
    end
    if (cfg.step_size < s2d9m_pkg::STEP_MIN) begin
      step_c = s2d9m_pkg::STEP_MIN;
    end else if (cfg.step_size > s2d9m_pkg::STEP_MAX) begin
      step_c = s2d9m_pkg::STEP_MAX;
    end else begin
      step_c = cfg.step_size;
    end
  end

  // position of the incoming sample, wrapping at once if the frame shrank
  always_comb begin
    col_wrap = (DW'(col_count) >= cols_c);
    row_inc  = DW'(row_count) + (col_wrap ? DW'(1) : DW'(0));
    r_now    = (row_inc >= rows_c) ? '0 : row_inc;
    c_now    = col_wrap ? '0 : DW'(col_count);
    c_plus   = c_now + DW'(1);
    r_plus   = r_now + DW'(1);
    if (c_plus >= cols_c) begin
      col_count_next = '0;
      row_count_next = (r_plus >= rows_c) ? '0 : r_plus[RW-1:0];
    end else begin
      col_count_next = c_plus[CW-1:0];
      row_count_next = r_now[RW-1:0];
    end
  end

  // count every item in flight so nothing is dropped at the queue
  assign credit_used = CU_W'(mq_count) + CU_W'(s1_valid) + CU_W'(mq_push);
  assign full        = (credit_used >= CU_W'(s2d9m_pkg::MQ_DEPTH));
  assign accept      = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        row_count <= row_count_next;
        col_count <= col_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= r_now[RW-1:0];
      s1_col <= c_now[CW-1:0];
      s1_cur <= sample;
    end
  end

  // word holds {two rows up, one row up}
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[c_now[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= {line_rd[SW-1:0], s1_cur};
    end
  end

  always_comb begin
    s1_up   = line_rd[2*SW-1:SW];
    s1_mid  = line_rd[SW-1:0];
    col_sum = CSW'(s1_up) + CSW'(s1_mid) + CSW'(s1_cur);
    row_e   = DW'(s1_row);
    col_e   = DW'(s1_col);
    cr      = row_e - DW'(1);
    cc      = col_e - DW'(1);
    s1_res  = (row_e >= DW'(2)) && (col_e >= DW'(2)) &&
              s2d9m_pkg::step_divides(s2d9m_pkg::DIV_W'(row_e - DW'(2)), step_c) &&
              s2d9m_pkg::step_divides(s2d9m_pkg::DIV_W'(col_e - DW'(2)), step_c);
    // last computed row/col: no further point fits before the border
    s1_last = (row_e + DW'(step_c) >= rows_c) && (col_e + DW'(step_c) >= cols_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      win[0]   <= '0;
      win[1]   <= '0;
      win[2]   <= '0;
    end else begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        win[0] <= col_sum;
        win[1] <= win[0];
        win[2] <= win[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_res  <= s1_res;
      s2_row  <= cr[IW-1:0];
      s2_col  <= cc[IW-1:0];
      s2_last <= s1_last;
    end
  end

  assign mq_push          = s2_valid && s2_res;
  assign mq_item.total    = TW'(win[0]) + TW'(win[1]) + TW'(win[2]);
  assign mq_item.tag.row  = s2_row;
  assign mq_item.tag.col  = s2_col;
  assign mq_item.tag.last = s2_last;

  // read and write of the line memory never meet at one address
  a_line_no_collide: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && accept) |-> (c_now[CW-1:0] != s1_col))
    else $error("line memory read and write collide");

endmodule

// ===== sv/s2d9m_back.sv =====
// ----------------------------------------------------------------------------
// s2d9m_back
// Rounded divide by nine of the window sum, four pipeline stages.
// ----------------------------------------------------------------------------
module s2d9m_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         mq_empty,
  input  s2d9m_pkg::mid_item_t         mq_item,
  output logic                         mq_pop,
  input  logic [s2d9m_pkg::OQ_CW-1:0]  oq_count,
  output logic                         oq_push,
  output s2d9m_pkg::out_item_t         oq_item
);

  localparam int TW   = s2d9m_pkg::SUM_W;
  localparam int MW   = s2d9m_pkg::MAG_W;
  localparam int LW   = s2d9m_pkg::LO_W;
  localparam int HW   = s2d9m_pkg::HI_W;
  localparam int PW   = s2d9m_pkg::PROD_W;
  localparam int SW   = s2d9m_pkg::SAMPLE_W;
  localparam int OU_W = s2d9m_pkg::OQ_CW + 1;

  logic [OU_W-1:0] credit_used;
  logic [TW-1:0]   sum_adj;

  logic                    b1_valid;
  logic                    b2_valid;
  logic                    b3_valid;
  logic                    b4_valid;
  logic [MW-1:0]           b1_x;
  logic                    b1_neg;
  logic                    b2_neg;
  logic                    b3_neg;
  s2d9m_pkg::res_tag_t     b1_tag;
  s2d9m_pkg::res_tag_t     b2_tag;
  s2d9m_pkg::res_tag_t     b3_tag;
  s2d9m_pkg::res_tag_t     b4_tag;
  logic [2*HW-1:0]         pp_hh;
  logic [HW+LW-1:0]        pp_hl;
  logic [HW+LW-1:0]        pp_lh;
  logic [2*LW-1:0]         pp_ll;
  logic [PW-1:0]           prod;
  logic [SW-1:0]           b3_q;
  logic [SW-1:0]           b4_mean;

  assign credit_used = OU_W'(oq_count) + OU_W'(b1_valid) + OU_W'(b2_valid) +
                       OU_W'(b3_valid) + OU_W'(b4_valid);
  assign mq_pop      = !mq_empty && (credit_used < OU_W'(s2d9m_pkg::OQ_DEPTH));

  // magnitude plus rounding bias; for negative sums -t + 4 = ~t + 5
  assign sum_adj = mq_item.total[TW-1] ?
                   (~mq_item.total + s2d9m_pkg::ROUND_BIAS + TW'(1)) :
                   (mq_item.total + s2d9m_pkg::ROUND_BIAS);

  assign prod = (PW'(pp_hh) << (2 * LW)) + (PW'(pp_hl) << LW) +
                (PW'(pp_lh) << LW) + PW'(pp_ll);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
    end else begin
      b1_valid <= mq_pop;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      b4_valid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      b1_x   <= sum_adj[MW-1:0];
      b1_neg <= mq_item.total[TW-1];
      b1_tag <= mq_item.tag;
    end
    if (b1_valid) begin
      pp_hh  <= b1_x[MW-1:LW] * s2d9m_pkg::RECIP9_HI;
      pp_hl  <= b1_x[MW-1:LW] * s2d9m_pkg::RECIP9_LO;
      pp_lh  <= b1_x[LW-1:0] * s2d9m_pkg::RECIP9_HI;
      pp_ll  <= b1_x[LW-1:0] * s2d9m_pkg::RECIP9_LO;
      b2_neg <= b1_neg;
      b2_tag <= b1_tag;
    end
    if (b2_valid) begin
      b3_q   <= prod[s2d9m_pkg::RECIP_SHIFT +: SW];
      b3_neg <= b2_neg;
      b3_tag <= b2_tag;
    end
    if (b3_valid) begin
      b4_mean <= b3_neg ? (~b3_q + SW'(1)) : b3_q;
      b4_tag  <= b3_tag;
    end
  end

  assign oq_push      = b4_valid;
  assign oq_item.mean = b4_mean;
  assign oq_item.tag  = b4_tag;

  // quotient bounds: at most 2^31 in magnitude, below it for non-negative sums
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    b3_valid |-> (b3_q <= 32'h8000_0000))
    else $error("mean quotient out of range");

  a_q_sign: assert property (@(posedge clk) disable iff (rst)
    (b3_valid && !b3_neg) |-> !b3_q[SW-1])
    else $error("non-negative sum gave negative mean");

endmodule

// ===== sv/stencil_2d_nine_point_mean.sv =====
// ----------------------------------------------------------------------------
// stencil_2d_nine_point_mean
// 3x3 box mean over a raster stream of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// path: a result passes the front window, the mid queue, the divide pipeline and the output queue
// throughput: one sample per cycle while full is low, set by the one read and one
//   write per cycle of the line memory and the fully pipelined divide by nine
// reset: counters, column window, queues, config registers and valid flags return to their reset
//   values at once; the line memory is not cleared and needs no clearing pass
module stencil_2d_nine_point_mean #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [s2d9m_pkg::SAMPLE_W-1:0] sample,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [s2d9m_pkg::SAMPLE_W-1:0] mean_value,
  output logic [s2d9m_pkg::IDX_W-1:0]           out_row,
  output logic [s2d9m_pkg::IDX_W-1:0]           out_col,
  output logic                                  frame_last,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [s2d9m_pkg::CFG_W-1:0]           cfg_data
);

  localparam int MID_W = $bits(s2d9m_pkg::mid_item_t);
  localparam int OUT_W = $bits(s2d9m_pkg::out_item_t);

  s2d9m_pkg::cfg_t                cfg;
  logic                           mq_push;
  logic                           mq_pop;
  logic                           mq_empty;
  logic [s2d9m_pkg::MQ_CW-1:0]    mq_count;
  s2d9m_pkg::mid_item_t           mq_item;
  logic [MID_W-1:0]               mq_head_bits;
  s2d9m_pkg::mid_item_t           mq_head;
  logic                           oq_push;
  logic [s2d9m_pkg::OQ_CW-1:0]    oq_count;
  s2d9m_pkg::out_item_t           oq_item;
  logic [OUT_W-1:0]               oq_head_bits;
  s2d9m_pkg::out_item_t           oq_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows <= s2d9m_pkg::GRID_ROWS_RST;
      cfg.grid_cols <= s2d9m_pkg::GRID_COLS_RST;
      cfg.step_size <= s2d9m_pkg::STEP_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        s2d9m_pkg::REG_GRID_ROWS: cfg.grid_rows <= cfg_data[s2d9m_pkg::ROWS_W-1:0];
        s2d9m_pkg::REG_GRID_COLS: cfg.grid_cols <= cfg_data[s2d9m_pkg::ROWS_W-1:0];
        s2d9m_pkg::REG_STEP_SIZE: cfg.step_size <= cfg_data[s2d9m_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  s2d9m_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .sample   (sample),
    .mq_count (mq_count),
    .mq_push  (mq_push),
    .mq_item  (mq_item)
  );

  s2d9m_queue #(
    .WIDTH (MID_W),
    .DEPTH (s2d9m_pkg::MQ_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (mq_push),
    .push_data (MID_W'(mq_item)),
    .pop       (mq_pop),
    .pop_data  (mq_head_bits),
    .empty     (mq_empty),
    .count     (mq_count)
  );

  assign mq_head = s2d9m_pkg::mid_item_t'(mq_head_bits);

  s2d9m_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mq_empty (mq_empty),
    .mq_item  (mq_head),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_item  (oq_item)
  );

  s2d9m_queue #(
    .WIDTH (OUT_W),
    .DEPTH (s2d9m_pkg::OQ_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (oq_push),
    .push_data (OUT_W'(oq_item)),
    .pop       (pop),
    .pop_data  (oq_head_bits),
    .empty     (empty),
    .count     (oq_count)
  );

  assign oq_head    = s2d9m_pkg::out_item_t'(oq_head_bits);
  assign mean_value = oq_head.mean;
  assign out_row    = oq_head.tag.row;
  assign out_col    = oq_head.tag.col;
  assign frame_last = oq_head.tag.last;

endmodule
